// ----- hdl/sixfk_pkg.sv -----
// shared types, constants and fixed-point helpers for the forward kinematics block
`default_nettype none
package sixfk_pkg;
  localparam int AngW   = 24;
  localparam int LenW   = 19;
  localparam int RotW   = 18;
  localparam int PosW   = 21;
  localparam int QW     = 32;
  localparam int NJoint = 6;
  localparam logic signed [AngW+1:0] HalfPiQ20 = 26'sd1647099;
  localparam logic [33:0] TurnScale = 34'd10937044409;
  localparam logic [31:0] PiQ30 = 32'd3373259426;
  localparam logic signed [QW-1:0] OneQ30 = 32'sd1073741824;
  localparam logic [1:0] CfgUpper = 2'd0;
  localparam logic [1:0] CfgFore  = 2'd1;
  localparam logic [1:0] CfgWrist = 2'd2;

  // reciprocal multipliers and shifts, exact for dividends below 2^30
  localparam logic [31:0] Rcp6     = 32'd1431655766;
  localparam int          Sh6      = 33;
  localparam logic [31:0] Rcp24    = 32'd1431655766;
  localparam int          Sh24     = 35;
  localparam logic [31:0] Rcp120   = 32'd1145324613;
  localparam int          Sh120    = 37;
  localparam logic [31:0] Rcp720   = 32'd1527099484;
  localparam int          Sh720    = 40;
  localparam logic [31:0] Rcp5040  = 32'd1745256553;
  localparam int          Sh5040   = 43;
  localparam logic [31:0] Rcp40320 = 32'd1745256553;
  localparam int          Sh40320  = 46;

  typedef logic signed [QW-1:0] q30_t;
  typedef logic signed [AngW+1:0] ang_t;

  typedef struct packed {
    q30_t s;
    q30_t c;
  } sc_t;

  // product of two q30 values, rounded half up
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    begin
      p = a * b + 64'sd536870912;
      qmul = q30_t'(p >>> 30);
    end
  endfunction

  function automatic logic signed [RotW-1:0] rot_sat(input logic signed [40:0] v);
    logic signed [40:0] t;
    begin
      t = (v + 41'sd8192) >>> 14;
      if (t > 41'sd65536) rot_sat = 18'sd65536;
      else if (t < -41'sd65536) rot_sat = -18'sd65536;
      else rot_sat = RotW'(t);
    end
  endfunction

  function automatic logic signed [PosW-1:0] pos_sat(input logic signed [40:0] v);
    begin
      if (v > 41'sd786432) pos_sat = 21'sd786432;
      else if (v < -41'sd786432) pos_sat = -21'sd786432;
      else pos_sat = PosW'(v);
    end
  endfunction
endpackage
`default_nettype wire

// ----- hdl/six_axis_forward_kinematics.sv -----
// top level: six-axis forward kinematics stream block
// input transaction: six joint angles, output transaction: one pose
// in_tdata holds joint_angle_1..6, 24 bits each, lowest first
// out_tdata holds rot_nx rot_ox rot_ax pos_x rot_ny rot_oy rot_ay pos_y
//   rot_nz rot_oz rot_az pos_z, lowest first
// throughput: one transaction per cycle while out_tready is high
// the path from input to output runs through the nine-stage lane
//   pipeline (phase, fold, scale, power products, series terms, sums,
//   quadrant) and the three-stage merge
// the pipeline advances only when its end is free; a stall on out_tready
// holds every stage, and in_tready follows the output being empty or taken
// reset clears the valid bits and loads the default link lengths
`default_nettype none
module six_axis_forward_kinematics
  import sixfk_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [143:0] in_tdata,   // joint_angle_1 .. joint_angle_6
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [231:0]      out_tdata,  // nx ox ax px ny oy ay py nz oz az pz
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [LenW-1:0] cfg_data
);
  localparam int Lat = 12;
  logic [Lat-1:0] vld_r;
  logic en;
  logic [LenW-1:0] l2_r, l3_r, l5_r;
  ang_t a [NJoint];
  ang_t t3, t4;
  sc_t sc [NJoint];

  assign en = !vld_r[Lat-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      l2_r <= 19'd29819; l3_r <= 19'd43909; l5_r <= 19'd12452;
    end else begin
      if (en) vld_r <= {vld_r[Lat-2:0], in_tvalid};
      if (cfg_we) begin
        case (cfg_index)
          CfgUpper: l2_r <= cfg_data;
          CfgFore:  l3_r <= cfg_data;
          CfgWrist: l5_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NJoint; i++) a[i] = ang_t'($signed(in_tdata[i*AngW +: AngW]));
    t3 = a[2] + a[1] + HalfPiQ20;
    t4 = a[3] + t3;
  end

  for (genvar g = 0; g < NJoint; g++) begin : g_lane
    sixfk_sincos u_sc (.clk(clk), .en(en),
      .ang(g == 2 ? t3 : (g == 3 ? t4 : a[g])), .sc(sc[g]));
  end

  sixfk_merge u_merge (.clk(clk), .en(en), .sc(sc), .l2(l2_r), .l3(l3_r), .l5(l5_r),
    .pose(out_tdata));

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("pose changed under stall");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready low with empty output");
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready) else $error("ready low while output is taken");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid after reset");
endmodule
`default_nettype wire

// ----- hdl/sixfk_sincos.sv -----
// pipelined sine and cosine lane: phase, octant fold, polynomial powers, series, quadrant
`default_nettype none
module sixfk_sincos
  import sixfk_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire ang_t ang,
  output sc_t       sc
);
  logic [31:0] p_r;
  logic [1:0]  quad_r [0:6];
  logic        swap_r [0:6];
  logic [29:0] u_r;
  q30_t x_r, xb_r, xc_r, xd_r, xe_r;
  q30_t x2_r, x2b_r, x2c_r, x3_r, x3c_r, x4_r, x4b_r, x5_r, x6_r, x7_r, x8_r;
  q30_t q3_r, q4_r, q5_r, q6_r, q7_r, q8_r, h2_r;
  q30_t sn_r, cs_r, sn_f, qs, qc;
  logic [59:0] prod;
  logic [29:0] ufold;
  logic [63:0] xm;

  // quotient of a nonnegative value below 2^30 by a constant
  function automatic q30_t rcp_div(input q30_t n, input logic [31:0] m, input int k);
    logic [61:0] pr;
    begin
      pr = n[29:0] * m;
      rcp_div = q30_t'(pr >> k);
    end
  endfunction

  assign prod = 60'(ang * $signed({1'b0, TurnScale}));
  assign ufold = (p_r[29:0] >= 30'h2000_0000) ? 30'(31'h4000_0000 - {1'b0, p_r[29:0]})
                                              : p_r[29:0];
  assign xm = u_r * PiQ30 + 64'h4000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= prod[55:24];
      quad_r[0] <= p_r[31:30];
      swap_r[0] <= p_r[29:0] >= 30'h2000_0000;
      u_r <= ufold;
      x_r <= $signed(xm[62:31]);
      x2_r <= qmul(x_r, x_r); xb_r <= x_r;
      x3_r <= qmul(x2_r, xb_r); x4_r <= qmul(x2_r, x2_r);
      x2b_r <= x2_r; xc_r <= xb_r;
      x5_r <= qmul(x4_r, xc_r); x6_r <= qmul(x4_r, x2b_r);
      x8_r <= qmul(x4_r, x4_r);
      x3c_r <= x3_r; x4b_r <= x4_r; x2c_r <= x2b_r; xd_r <= xc_r;
      x7_r <= qmul(x6_r, xd_r); xe_r <= xd_r;
      q3_r <= rcp_div(x3c_r, Rcp6, Sh6);
      q5_r <= rcp_div(x5_r, Rcp120, Sh120);
      h2_r <= x2c_r >>> 1;
      q4_r <= rcp_div(x4b_r, Rcp24, Sh24);
      q6_r <= rcp_div(x6_r, Rcp720, Sh720);
      q8_r <= rcp_div(x8_r, Rcp40320, Sh40320);
      q7_r <= rcp_div(x7_r, Rcp5040, Sh5040);
      sn_r <= xe_r - q3_r + q5_r;
      cs_r <= OneQ30 - h2_r + q4_r - q6_r + q8_r;
      for (int i = 1; i < 7; i++) begin
        quad_r[i] <= quad_r[i-1];
        swap_r[i] <= swap_r[i-1];
      end
      case (quad_r[6])
        2'd0: sc <= '{s: qs, c: qc};
        2'd1: sc <= '{s: qc, c: -qs};
        2'd2: sc <= '{s: -qs, c: -qc};
        default: sc <= '{s: -qc, c: qs};
      endcase
    end
  end

  assign sn_f = sn_r - q7_r;
  assign qs = swap_r[6] ? cs_r : sn_f;
  assign qc = swap_r[6] ? sn_f : cs_r;
endmodule
`default_nettype wire

// ----- hdl/sixfk_merge.sv -----
// merge stage: combines lane results into rotation and position
`default_nettype none
module sixfk_merge
  import sixfk_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire sc_t  sc [NJoint],
  input  wire logic [LenW-1:0] l2,
  input  wire logic [LenW-1:0] l3,
  input  wire logic [LenW-1:0] l5,
  output logic [231:0] pose
);
  q30_t c1, s1, c4, s4, c5, s5, c6, s6;
  q30_t c1s4_r, s1s4_r, c1c4_r, s1c4_r, s1s5_r, c1s5_r, c4c5_r, c4s5_r;
  q30_t c1c5_r, s1c5_r;
  q30_t c1b_r, s1b_r, s4b_r, s5b_r, c5b_r, s6b_r, c6b_r;
  q30_t a_r, b_r, ax_r, ay_r, c4c5c6_r, c4c5s6_r, c1c4b_r, s1c4b_r, s4b2_r, c4s5b_r;
  q30_t c6c_r, s6c_r, c1c_r, s1c_r;
  logic signed [63:0] rs_r, zs_r;
  q30_t r_r, z_r;
  logic signed [RotW-1:0] nx, ox, ax, ny, oy, ay, nz, oz, az;
  logic signed [PosW-1:0] px, py, pz;

  assign {c1, s1} = {sc[0].c, sc[0].s};
  assign {c4, s4} = {sc[3].c, sc[3].s};
  assign {c5, s5} = {sc[4].c, sc[4].s};
  assign {c6, s6} = {sc[5].c, sc[5].s};

  always_ff @(posedge clk) begin
    if (en) begin
      c1s4_r <= qmul(c1, s4); s1s4_r <= qmul(s1, s4);
      c1c4_r <= qmul(c1, c4); s1c4_r <= qmul(s1, c4);
      s1s5_r <= qmul(s1, s5); c1s5_r <= qmul(c1, s5);
      c4c5_r <= qmul(c4, c5); c4s5_r <= qmul(c4, s5);
      c1c5_r <= qmul(c1, c5); s1c5_r <= qmul(s1, c5);
      c1b_r <= c1; s1b_r <= s1; s4b_r <= s4; s5b_r <= s5; c5b_r <= c5;
      s6b_r <= s6; c6b_r <= c6;
      rs_r <= $signed({1'b0, l2}) * sc[1].c + $signed({1'b0, l3}) * sc[2].c
            + $signed({1'b0, l5}) * c4;
      zs_r <= $signed({1'b0, l2}) * sc[1].s + $signed({1'b0, l3}) * sc[2].s
            + $signed({1'b0, l5}) * s4;
      // stage 2
      a_r <= qmul(c1s4_r, c5b_r) + s1s5_r;
      b_r <= qmul(s1s4_r, c5b_r) - c1s5_r;
      ax_r <= qmul(c1s4_r, s5b_r) - s1c5_r;
      ay_r <= qmul(s1s4_r, s5b_r) + c1c5_r;
      c4c5c6_r <= qmul(c4c5_r, c6b_r);
      c4c5s6_r <= qmul(c4c5_r, s6b_r);
      c1c4b_r <= c1c4_r; s1c4b_r <= s1c4_r; s4b2_r <= s4b_r; c4s5b_r <= c4s5_r;
      c6c_r <= c6b_r; s6c_r <= s6b_r; c1c_r <= c1b_r; s1c_r <= s1b_r;
      r_r <= q30_t'((rs_r + 64'sd536870912) >>> 30);
      z_r <= q30_t'((zs_r + 64'sd536870912) >>> 30);
      pose <= {7'd0, pz, az, oz, nz, py, ay, oy, ny, px, ax, ox, nx};
    end
  end

  always_comb begin
    nx = rot_sat(41'(qmul(a_r, c6c_r)) + 41'(qmul(c1c4b_r, s6c_r)));
    ox = rot_sat(-41'(qmul(a_r, s6c_r)) + 41'(qmul(c1c4b_r, c6c_r)));
    ax = rot_sat(41'(ax_r));
    ny = rot_sat(41'(qmul(b_r, c6c_r)) + 41'(qmul(s1c4b_r, s6c_r)));
    oy = rot_sat(-41'(qmul(b_r, s6c_r)) + 41'(qmul(s1c4b_r, c6c_r)));
    ay = rot_sat(41'(ay_r));
    nz = rot_sat(41'(c4c5c6_r) - 41'(qmul(s4b2_r, s6c_r)));
    oz = rot_sat(-41'(c4c5s6_r) - 41'(qmul(s4b2_r, c6c_r)));
    az = rot_sat(41'(c4s5b_r));
    px = pos_sat(41'(qmul(r_r, c1c_r)));
    py = pos_sat(41'(qmul(r_r, s1c_r)));
    pz = pos_sat(-41'(z_r));
  end
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// testbench for the six-axis forward kinematics stream block
module testbench;
  import sixfk_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [RotW-1:0] rot [9];
    logic signed [PosW-1:0] pos [3];
  } pose_t;

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  function automatic longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [RotW-1:0] to_rot(longint v);
    return RotW'(clamp(round_shift(v, 14), 65536));
  endfunction

  function automatic logic signed [PosW-1:0] to_pos(longint v);
    return PosW'(clamp(v, 786432));
  endfunction

  function automatic void joint_sin_cos(longint ang, output longint s, output longint c);
    logic [63:0] prod;
    logic [31:0] ph;
    logic [1:0] quad;
    longint u, x, x2, x3, x4, x5, x6, x7, x8, sn, cs, qs, qc;
    bit swap;
    prod = ang * 64'd10937044409;
    ph = prod[55:24];
    quad = ph[31:30];
    u = ph[29:0];
    swap = 0;
    if (u >= (64'd1 << 29)) begin
      u = (64'd1 << 30) - u;
      swap = 1;
    end
    x = longint'((u * 64'd3373259426 + (64'd1 << 30)) >> 31);
    x2 = fx_mul(x, x);
    x3 = fx_mul(x2, x);
    x4 = fx_mul(x2, x2);
    x5 = fx_mul(x4, x);
    x6 = fx_mul(x4, x2);
    x7 = fx_mul(x6, x);
    x8 = fx_mul(x4, x4);
    sn = x - x3 / 6 + x5 / 120 - x7 / 5040;
    cs = 64'sd1073741824 - x2 / 2 + x4 / 24 - x6 / 720 + x8 / 40320;
    qs = swap ? cs : sn;
    qc = swap ? sn : cs;
    case (quad)
      2'd0: begin s = qs; c = qc; end
      2'd1: begin s = qc; c = -qs; end
      2'd2: begin s = -qs; c = -qc; end
      default: begin s = -qc; c = qs; end
    endcase
  endfunction

  class pose_scoreboard;
    longint upper_len = 29819, fore_len = 43909, wrist_len = 12452;
    pose_t pending [$];
    int errors = 0;

    function void note_angles(logic [143:0] d);
      longint t [6], s [6], c [6];
      longint a, b, r, z;
      pose_t p;
      for (int i = 0; i < 6; i++) t[i] = longint'($signed(d[i*24 +: 24]));
      t[2] += t[1] + 1647099;
      t[3] += t[2];
      for (int i = 0; i < 6; i++) joint_sin_cos(t[i], s[i], c[i]);
      a = fx_mul(fx_mul(c[0], s[3]), c[4]) + fx_mul(s[0], s[4]);
      b = fx_mul(fx_mul(s[0], s[3]), c[4]) - fx_mul(c[0], s[4]);
      r = round_shift(upper_len * c[1] + fore_len * c[2] + wrist_len * c[3], 30);
      z = round_shift(upper_len * s[1] + fore_len * s[2] + wrist_len * s[3], 30);
      p.rot[0] = to_rot(fx_mul(a, c[5]) + fx_mul(fx_mul(c[0], c[3]), s[5]));
      p.rot[1] = to_rot(-fx_mul(a, s[5]) + fx_mul(fx_mul(c[0], c[3]), c[5]));
      p.rot[2] = to_rot(fx_mul(fx_mul(c[0], s[3]), s[4]) - fx_mul(s[0], c[4]));
      p.rot[3] = to_rot(fx_mul(b, c[5]) + fx_mul(fx_mul(s[0], c[3]), s[5]));
      p.rot[4] = to_rot(-fx_mul(b, s[5]) + fx_mul(fx_mul(s[0], c[3]), c[5]));
      p.rot[5] = to_rot(fx_mul(fx_mul(s[0], s[3]), s[4]) + fx_mul(c[0], c[4]));
      p.rot[6] = to_rot(fx_mul(fx_mul(c[3], c[4]), c[5]) - fx_mul(s[3], s[5]));
      p.rot[7] = to_rot(-fx_mul(fx_mul(c[3], c[4]), s[5]) - fx_mul(s[3], c[5]));
      p.rot[8] = to_rot(fx_mul(c[3], s[4]));
      p.pos[0] = to_pos(fx_mul(r, c[0]));
      p.pos[1] = to_pos(fx_mul(r, s[0]));
      p.pos[2] = to_pos(-z);
      pending.push_back(p);
    endfunction

    function void check_pose(logic [231:0] d);
      pose_t e;
      logic signed [RotW-1:0] got_rot [9];
      logic signed [PosW-1:0] got_pos [3];
      int ri, pi_;
      if (pending.size() == 0) begin
        $display("%0t: unexpected pose, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      ri = 0;
      pi_ = 0;
      // fields: nx ox ax px ny oy ay py nz oz az pz
      for (int g = 0; g < 3; g++) begin
        for (int k = 0; k < 3; k++) begin
          got_rot[ri] = d[g*75 + k*18 +: 18];
          if (got_rot[ri] !== e.rot[ri]) begin
            $display("%0t: rot %0d expected %0d, actual %0d", $time, ri, e.rot[ri],
                     got_rot[ri]);
            errors++;
          end
          ri++;
        end
        got_pos[pi_] = d[g*75 + 54 +: 21];
        if (got_pos[pi_] !== e.pos[pi_]) begin
          $display("%0t: pos %0d expected %0d, actual %0d", $time, pi_, e.pos[pi_],
                   got_pos[pi_]);
          errors++;
        end
        pi_++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [143:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0;
  logic [231:0] out_tdata;
  logic cfg_we = 0;
  logic [1:0] cfg_index = CfgUpper;
  logic [LenW-1:0] cfg_data = '0;
  pose_scoreboard board = new();
  bit hold_off = 0;
  longint cycles = 0;

  six_axis_forward_kinematics dut (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_pose(out_tdata);
    if (rst_n && in_tvalid && in_tready) board.note_angles(in_tdata);
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (hold_off) out_tready <= 0;
    else if (cycles % 200 < 60) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_length(logic [1:0] idx, logic [LenW-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CfgUpper: board.upper_len = longint'(val);
      CfgFore: board.fore_len = longint'(val);
      CfgWrist: board.wrist_len = longint'(val);
      default: ;
    endcase
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_angles(logic [143:0] d);
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic pause_sender(int n);
    in_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    pause_sender(1);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return 24'(24'h800000 + $urandom_range(0, 3));
      1: return 24'(24'h7FFFFF - $urandom_range(0, 3));
      2: return 24'($urandom_range(0, 6588397) - 3294198);
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_burst(int count);
    logic [143:0] d;
    int sent;
    sent = 0;
    while (sent < count) begin
      for (int b = $urandom_range(1, 20); b > 0 && sent < count; b--) begin
        for (int j = 0; j < 6; j++) d[j*24 +: 24] = rand_angle();
        send_angles(d);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 8));
    end
  endtask

  initial begin
    logic [143:0] d;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: zero, extremes, quarter and half turns, single-joint eighth turns, alternating patterns
    send_angles('0);
    send_angles({6{24'h800000}});
    send_angles({6{24'h7FFFFF}});
    send_angles({6{24'sd1647099}});
    send_angles({6{-24'sd1647099}});
    send_angles({6{24'sd3294198}});
    for (int j = 0; j < 6; j++) begin
      d = '0;
      d[j*24 +: 24] = 24'sd823550;
      send_angles(d);
    end
    send_angles({24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA});
    send_angles({24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555});
    drain();
    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    fork
      begin repeat (60) @(posedge clk); hold_off = 0; end
      random_burst(40);
    join
    drain();
    random_burst(200);
    drain();
    write_length(CfgUpper, 19'h7FFFF);
    write_length(CfgFore, 19'h7FFFF);
    write_length(CfgWrist, 19'h7FFFF);
    random_burst(150);
    drain();
    write_length(CfgUpper, '0);
    write_length(CfgFore, '0);
    write_length(CfgWrist, '0);
    random_burst(150);
    drain();
    write_length(CfgUpper, 19'd262144);
    write_length(CfgFore, 19'd131072);
    write_length(CfgWrist, 19'd1);
    random_burst(180);
    drain();
    write_length(CfgUpper, LenW'($urandom_range(0, 262144)));
    write_length(CfgFore, LenW'($urandom_range(0, 262144)));
    write_length(CfgWrist, LenW'($urandom_range(0, 262144)));
    random_burst(160);
    drain();
    if (board.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
